### design/sha2_pkg.sv
// ----------------------------------------------------------------------------
// sha2_pkg
// Shared types, round constants and round functions of the SHA-256/224 core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha2_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // control from the sequencer to the compression unit
  typedef struct packed {
    logic        start;
    logic        restart;
    logic        mode;
    logic        wr_en;
    logic [3:0]  wr_lane;
    logic [3:0]  wr_mask;
    logic [31:0] wr_data;
  } sha2_ctl_t;

  localparam logic [2:0]  ADDR_MODE = 3'd0;

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [5:0]  LEN_FILL  = 6'd56;
  localparam logic [3:0]  LANE_LENH = 4'd14;
  localparam logic [3:0]  LANE_LENL = 4'd15;
  localparam logic [6:0]  ROUNDS    = 7'd64;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic mode, input logic [2:0] idx);
    logic [31:0] h;
    case ({mode, idx})
      4'h0: h = 32'h6a09e667;  4'h1: h = 32'hbb67ae85;
      4'h2: h = 32'h3c6ef372;  4'h3: h = 32'ha54ff53a;
      4'h4: h = 32'h510e527f;  4'h5: h = 32'h9b05688c;
      4'h6: h = 32'h1f83d9ab;  4'h7: h = 32'h5be0cd19;
      4'h8: h = 32'hc1059ed8;  4'h9: h = 32'h367cd507;
      4'ha: h = 32'h3070dd17;  4'hb: h = 32'hf70e5939;
      4'hc: h = 32'hffc00b31;  4'hd: h = 32'h68581511;
      4'he: h = 32'h64f98fa7;  4'hf: h = 32'hbefa4fa4;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

### design/sha2_compress.sv
// ----------------------------------------------------------------------------
// sha2_compress
// Hash state, message schedule window and one shared round datapath that
// runs the 64 compression rounds, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha2_compress
  import sha2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sha2_ctl_t   ctl,
  input  wire logic [2:0]  rd_idx,
  output logic [31:0]      digest,
  output logic             busy
);

  logic [31:0] hash [8];
  logic [31:0] win  [16];
  logic [31:0] v    [8];
  logic [6:0]  rnd;
  logic        rnd_run;
  logic        rnd_end;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] wmask;

  assign rnd_end = busy && (rnd == ROUNDS);
  assign rnd_run = busy && (rnd != ROUNDS);

  // window holds W[t-16..t-1]; W[t] for t < 16 is already at the head
  assign w_new = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
  assign w_cur = rnd[6:4] == 3'd0 ? win[0] : w_new;
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + round_k(rnd[5:0]) + w_cur;
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign wmask = {{8{ctl.wr_mask[3]}}, {8{ctl.wr_mask[2]}},
                  {8{ctl.wr_mask[1]}}, {8{ctl.wr_mask[0]}}};

  assign digest = hash[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (rnd_end) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (busy) begin
      rnd <= rnd + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (rst) begin
        hash[i] <= init_hash(1'b0, 3'(i));
      end else if (ctl.restart) begin
        hash[i] <= init_hash(ctl.mode, 3'(i));
      end else if (rnd_end) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (rnd_run) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_run) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_cur;
    end else if (ctl.wr_en) begin
      win[ctl.wr_lane] <= (win[ctl.wr_lane] & ~wmask) | (ctl.wr_data & wmask);
    end
  end

endmodule

`default_nettype wire

### design/sha256_sha224_hash_core.sv
// ----------------------------------------------------------------------------
// sha256_sha224_hash_core
// SHA-256 / SHA-224 core: packs message words into 64-byte blocks, pads the
// final block, compresses and streams out the digest words.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_ready  in_word_t  (message_word, byte_count, last)
//   out      out  out_valid/out_ready out_word_t (digest_word, word_index, last)
//   cfg      in   APB psel/penable   mode_224 at address 0 (decoded on paddr[2] low)
//
// A full word on a lane boundary is accepted, written as one lane and then the
// core returns to idle; otherwise each valid byte takes its own write (up to
// 4). A full block runs in the round unit, one round per cycle. Padding writes
// one byte or one aligned lane per cycle, waiting while a full block compresses,
// then two length lanes. Reset is synchronous; the core accepts no word while a
// message word or the digest is in progress; each digest word is held until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_sha224_hash_core
  import sha2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PACK  = 3'd1;
  localparam logic [2:0] S_PAD80 = 3'd2;
  localparam logic [2:0] S_PADZ  = 3'd3;
  localparam logic [2:0] S_LENHI = 3'd4;
  localparam logic [2:0] S_LENLO = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state, state_next;
  logic [2:0]  ret, ret_next;
  logic [31:0] wbuf, wbuf_next;
  logic [2:0]  rem, rem_next;
  logic        last_f, last_f_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] bitlen, bitlen_next;
  logic [2:0]  oidx, oidx_next;
  logic        mode;
  logic        cfg_wr;
  logic [2:0]  in_cnt;
  logic [6:0]  fill_sum;
  logic        full_lane;
  logic [31:0] digest;
  logic        busy;
  logic        out_last;
  sha2_ctl_t   ctl;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_MODE[2]);
  assign pready = 1'b1;
  assign prdata = {31'd0, mode & (paddr[2] == ADDR_MODE[2])};

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_cnt    = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
  assign out_last  = (oidx == (mode ? 3'd6 : 3'd7));

  assign out_data.digest_word = digest;
  assign out_data.word_index  = oidx;
  assign out_data.last_word   = out_last;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    wbuf_next   = wbuf;
    rem_next    = rem;
    last_f_next = last_f;
    fill_next   = fill;
    bitlen_next = bitlen;
    oidx_next   = oidx;
    full_lane   = (fill[1:0] == 2'd0);
    fill_sum    = {1'b0, fill} + 7'd1;
    ctl         = '0;
    ctl.mode    = mode;
    ctl.wr_lane = fill[5:2];
    ctl.wr_mask = 4'b1000 >> fill[1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          wbuf_next   = in_data.message_word;
          rem_next    = in_cnt;
          last_f_next = in_data.last_item;
          bitlen_next = bitlen + {58'd0, in_cnt, 3'd0};
          state_next  = S_PACK;
        end
      end
      S_PACK: begin
        if (rem == 3'd0) begin
          state_next = last_f ? S_PAD80 : S_IDLE;
        end else begin
          ctl.wr_en = 1'b1;
          if (full_lane && rem == 3'd4) begin
            ctl.wr_mask = 4'b1111;
            ctl.wr_data = wbuf;
            fill_sum    = {1'b0, fill} + 7'd4;
            rem_next    = 3'd0;
          end else begin
            ctl.wr_data = {4{wbuf[31:24]}};
            wbuf_next   = {wbuf[23:0], 8'd0};
            rem_next    = rem - 3'd1;
          end
          fill_next = fill_sum[5:0];
          if (fill_sum[6]) begin
            ctl.start  = 1'b1;
            ret_next   = S_PACK;
            state_next = S_WAIT;
          end
        end
      end
      S_PAD80: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_data = {4{PAD_BYTE}};
        fill_next   = fill_sum[5:0];
        if (fill_sum[6]) begin
          ctl.start  = 1'b1;
          ret_next   = S_PADZ;
          state_next = S_WAIT;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADZ: begin
        if (fill == LEN_FILL) begin
          state_next = S_LENHI;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_data = 32'd0;
          if (full_lane) begin
            ctl.wr_mask = 4'b1111;
            fill_sum    = {1'b0, fill} + 7'd4;
          end
          fill_next = fill_sum[5:0];
          if (fill_sum[6]) begin
            ctl.start  = 1'b1;
            ret_next   = S_PADZ;
            state_next = S_WAIT;
          end
        end
      end
      S_LENHI: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_lane = LANE_LENH;
        ctl.wr_mask = 4'b1111;
        ctl.wr_data = bitlen[63:32];
        state_next  = S_LENLO;
      end
      S_LENLO: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_lane = LANE_LENL;
        ctl.wr_mask = 4'b1111;
        ctl.wr_data = bitlen[31:0];
        ctl.start   = 1'b1;
        fill_next   = 6'd0;
        oidx_next   = 3'd0;
        ret_next    = S_OUT;
        state_next  = S_WAIT;
      end
      S_WAIT: begin
        if (!busy) begin
          state_next = ret;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_next = oidx + 3'd1;
          if (out_last) begin
            ctl.restart = 1'b1;
            bitlen_next = 64'd0;
            fill_next   = 6'd0;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cfg_wr) begin
      ctl.restart = 1'b1;
      ctl.mode    = pwdata[0];
      bitlen_next = 64'd0;
      fill_next   = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      rem    <= 3'd0;
      last_f <= 1'b0;
      fill   <= 6'd0;
      bitlen <= 64'd0;
      oidx   <= 3'd0;
      mode   <= 1'b0;
    end else begin
      state  <= state_next;
      ret    <= ret_next;
      rem    <= rem_next;
      last_f <= last_f_next;
      fill   <= fill_next;
      bitlen <= bitlen_next;
      oidx   <= oidx_next;
      if (cfg_wr) begin
        mode <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    wbuf <= wbuf_next;
  end

  sha2_compress u_compress (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_idx (oidx),
    .digest (digest),
    .busy   (busy)
  );

`ifndef ASSERT_OFF
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready && !out_valid)
    else $error("word accepted or digest shown while rounds run");

  a_224_seven_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode |-> out_data.word_index != 3'd7)
    else $error("eighth digest word in 224 mode");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_word |=> bitlen == 64'd0 && fill == 6'd0)
    else $error("length or fill kept after digest");

  a_digest_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_data.word_index == 3'd0)
    else $error("digest does not start at word zero");
`endif

endmodule

`default_nettype wire

### verif/sha256_sha224_hash_core_tb.sv
// ----------------------------------------------------------------------------
// sha256_sha224_hash_core_tb
// Self-checking bench for the SHA-256/224 core. Messages go in as words
// over a valid/ready channel. A scoreboard hashes the same byte stream and
// checks every digest word in order. Mode writes go over APB, with and
// without abandoned partial messages, and both channels see random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_sha224_hash_core_tb;
  import sha2_pkg::*;

  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam bit         MODE_256    = 1'b0;
  localparam bit         MODE_224    = 1'b1;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         DRAIN_CYCLES   = 200;
  localparam int         TARGET_WORDS   = 430;
  localparam int         QUIET_TAIL     = 60;

  class digest_scoreboard;
    bit [31:0]   k_tab[64];
    bit [31:0]   iv_256[8];
    bit [31:0]   iv_224[8];
    bit          mode;
    bit [31:0]   hash[8];
    bit [7:0]    block_bytes[64];
    int unsigned fill;
    bit [63:0]   msg_bits;
    out_word_t   digest_q[$];
    int          errors;
    int          checked;
    int          messages;
    int          messages_224;

    function new();
      k_tab = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      iv_256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      iv_224 = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
                 32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
      mode = MODE_256;
      errors = 0;
      checked = 0;
      messages = 0;
      messages_224 = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hash[i] = mode ? iv_224[i] : iv_256[i];
      fill = 0;
      msg_bits = '0;
    endfunction

    function void set_mode(bit m);
      mode = m;
      restart();
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      bit [31:0] w[64];
      bit [31:0] v[8];
      bit [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash[i] = hash[i] + v[i];
    endfunction

    function void push_byte(bit [7:0] b);
      block_bytes[fill] = b;
      fill++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    endfunction

    function void absorb_word(in_word_t wd);
      int        nbytes;
      int        ndig;
      out_word_t e;
      nbytes = (wd.byte_count > 3'd4) ? 4 : int'(wd.byte_count);
      for (int i = 0; i < nbytes; i++) push_byte(wd.message_word[31-8*i -: 8]);
      msg_bits = msg_bits + 64'(nbytes * 8);
      if (!wd.last_item) return;
      // pad: 0x80, zeros to byte 56, then the 64-bit length
      push_byte(8'h80);
      while (fill != 56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      fill = 0;
      ndig = mode ? 7 : 8;
      for (int i = 0; i < ndig; i++) begin
        e.digest_word = hash[i];
        e.word_index  = 3'(i);
        e.last_word   = (i == ndig - 1);
        digest_q.insert(digest_q.size(), e);
      end
      messages++;
      if (mode) messages_224++;
      restart();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ERROR: %s", $time, msg);
    endtask

    task check_word(out_word_t got);
      out_word_t e;
      if (digest_q.size() == 0) begin
        report($sformatf("unexpected digest word %h", got.digest_word));
        return;
      end
      e = digest_q.pop_front();
      checked++;
      if (got.digest_word !== e.digest_word)
        report($sformatf("digest_word %h, expected %h (index %0d)",
                         got.digest_word, e.digest_word, e.word_index));
      if (got.word_index !== e.word_index)
        report($sformatf("word_index %0d, expected %0d", got.word_index, e.word_index));
      if (got.last_word !== e.last_word)
        report($sformatf("last_word %b, expected %b (index %0d)",
                         got.last_word, e.last_word, e.word_index));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  digest_scoreboard sb = new();
  bit  gaps_on;
  int  words_sent;
  int  words_taken;
  int  idle_cycles;

  sha256_sha224_hash_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.absorb_word(in_data);
        words_taken++;
      end
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  // watchdog: cycles with no handshake on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sha256_sha224_hash_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic in_word_t mk(logic [31:0] w, logic [2:0] n, logic l);
    in_word_t x;
    x.message_word = w;
    x.byte_count   = n;
    x.last_item    = l;
    return x;
  endfunction

  // called and returns at a falling edge
  task send_word(in_word_t wd);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_MODE) sb.set_mode(data[0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task apb_read_mode();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MODE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, sb.mode})
      sb.report($sformatf("mode readback %h, expected %0d", prdata, sb.mode));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task random_message(int nwords, bit abandon);
    logic [2:0] n;
    bit         l;
    for (int k = 0; k < nwords; k++) begin
      l = (k == nwords - 1) && !abandon;
      if (l || $urandom_range(0, 3) == 0) n = 3'($urandom_range(0, 7));
      else n = 3'd4;
      send_word(mk($urandom, n, l));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    words_sent = 0;
    words_taken = 0;
    idle_cycles = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty, "abc", short and oversized counts, zero count, 56 bytes
    send_word(mk(32'h0000_0000, 3'd0, 1'b1));
    send_word(mk(32'h6162_6300, 3'd3, 1'b1));
    send_word(mk(32'haabb_ccdd, 3'd2, 1'b0));
    send_word(mk(32'h1122_3344, 3'd1, 1'b0));
    send_word(mk(32'hffff_ffff, 3'd5, 1'b0));
    send_word(mk(32'h0102_0304, 3'd0, 1'b0));
    send_word(mk(32'h5566_7788, 3'd4, 1'b1));
    send_word(mk(32'hffff_ffff, 3'd7, 1'b1));
    for (int k = 0; k < 14; k++)
      send_word(mk((k % 3 == 0) ? 32'hffff_ffff : (k % 3 == 1) ? 32'h0 : $urandom,
                   3'd4, k == 13));
    wait_idle();
    apb_write(ADDR_MODE, 32'(MODE_224));
    apb_read_mode();
    send_word(mk(32'h6162_6300, 3'd3, 1'b1));
    // partial message dropped by a mode write
    send_word(mk($urandom, 3'd4, 1'b0));
    send_word(mk($urandom, 3'd4, 1'b0));
    wait_idle();
    apb_write(ADDR_MODE, 32'(MODE_224));
    apb_write(ADDR_UNUSED, 32'(MODE_256));
    apb_read_mode();
    send_word(mk(32'h0000_0000, 3'd0, 1'b1));

    while (words_sent < TARGET_WORDS) begin
      if (TARGET_WORDS - words_sent <= QUIET_TAIL) gaps_on = 1'b0;
      else gaps_on = ($urandom_range(0, 3) != 0);
      if ((TARGET_WORDS - words_sent > QUIET_TAIL) && $urandom_range(0, 4) == 0) begin
        wait_idle();
        apb_write(ADDR_MODE, $urandom_range(0, 1));
      end
      if ((TARGET_WORDS - words_sent > QUIET_TAIL) && $urandom_range(0, 11) == 0) begin
        random_message($urandom_range(1, 20), 1'b1);
        wait_idle();
        apb_write(ADDR_MODE, $urandom_range(0, 1));
      end else begin
        random_message(($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 12), 1'b0);
      end
    end

    gaps_on = 1'b0;
    in_valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d messages (%0d in SHA-224 mode) from %0d message words,",
             sb.messages, sb.messages_224, words_taken);
    $display("%0d digest words compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("sha256_sha224_hash_core_tb passed");
    end else begin
      $display("sha256_sha224_hash_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
